[design/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked implication, same reset handling.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

[design/lmts_pkg.sv]
package lmts_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } ppu_mode_e;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_SET_LCD = 1'b1;

  localparam int unsigned FrameW = 18;
  localparam int unsigned LineW  = 10;

  // Normal-speed boundaries
  localparam logic [LineW-1:0]  MODE3_AT  = 10'd80;
  localparam logic [LineW-1:0]  MODE0_AT  = 10'd248;
  localparam logic [LineW-1:0]  LINE_LEN  = 10'd456;
  localparam logic [FrameW-1:0] VBLANK_AT = 18'd65664;
  localparam logic [FrameW-1:0] FRAME_LEN = 18'd70224;

  // Double-speed boundaries
  localparam logic [LineW-1:0]  MODE3_AT_DS  = 10'd160;
  localparam logic [LineW-1:0]  MODE0_AT_DS  = 10'd496;
  localparam logic [LineW-1:0]  LINE_LEN_DS  = 10'd912;
  localparam logic [FrameW-1:0] VBLANK_AT_DS = 18'd131328;
  localparam logic [FrameW-1:0] FRAME_LEN_DS = 18'd140448;

  localparam logic [LineW-1:0]  LINE_STEP  = 10'd4;
  localparam logic [FrameW-1:0] FRAME_STEP = 18'd4;

  typedef struct packed {
    logic              lcd_enabled;
    logic              in_vblank;
    logic [FrameW-1:0] frame_cycles;
    logic [LineW-1:0]  line_cycles;
    ppu_mode_e         current_mode;
    logic [7:0]        scanline;
    logic              match_flag;
  } seq_state_t;

  typedef struct packed {
    logic       mode;
    logic       lcd_on;
    logic [7:0] lyc;
    logic [3:0] stat_int_enables;
  } step_in_t;

  // Pulses produced by one step
  typedef struct packed {
    logic stat_irq;
    logic vblank_irq;
    logic window_line_clear;
    logic frame_sync;
  } step_pulse_t;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 24;

endpackage

[design/lcd_mode_timing_sequencer_core.sv]
// LCD mode timing sequencer.
// A beat passes the input register, then the step logic into the result register.
// Throughput: one item per cycle while the output is not stalled by m_axis_tready low;
// the state update is a single pass of the step logic.
// Reset (rst_ni low, asynchronous): pipeline empty, LCD enabled, mode 2, line 0,
// counters and flags cleared, normal speed.
module lcd_mode_timing_sequencer_core
  import lmts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,      // double_speed
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] lcd_on, [8:1] lyc, [12:9] stat_int_enables, [15:13] zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] ppu_mode, [9:2] line_number, [10] coincidence, [11] vsync_flag,
  // [12] stat_irq, [13] vblank_irq, [14] window_line_clear, [15] frame_sync,
  // [16] lcd_active, [23:17] zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic                 in_valid_q;
  step_in_t             in_q;
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic                 ds_q;
  seq_state_t           st_q, st_d, st_step;
  step_pulse_t          pulse;
  logic                 advance, step_fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  lmts_step u_step (
    .state_i        (st_q),
    .item_i         (in_q),
    .double_speed_i (ds_q),
    .state_o        (st_step),
    .pulse_o        (pulse)
  );

  always_comb begin
    st_d = st_q;
    if (step_fire) begin
      st_d = st_step;
    end
    if (cfg_we_i) begin
      st_d.frame_cycles = '0;
      st_d.line_cycles  = '0;
    end
  end

  assign out_data_d = {7'd0, st_step.lcd_enabled, pulse.frame_sync,
                       pulse.window_line_clear, pulse.vblank_irq, pulse.stat_irq,
                       st_step.in_vblank, st_step.match_flag, st_step.scanline,
                       st_step.current_mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ds_q        <= 1'b0;
      st_q        <= '{lcd_enabled: 1'b1, in_vblank: 1'b0, frame_cycles: '0,
                       line_cycles: '0, current_mode: MODE_OAM, scanline: 8'd0,
                       match_flag: 1'b0};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_we_i) begin
        ds_q <= cfg_wdata_i;
      end
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= '{mode: s_axis_tuser, lcd_on: s_axis_tdata[0], lyc: s_axis_tdata[8:1],
                stat_int_enables: s_axis_tdata[12:9]};
    end
    if (step_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[design/lmts_step.sv]
module lmts_step
  import lmts_pkg::*;
(
  input  seq_state_t  state_i,
  input  step_in_t    item_i,
  input  logic        double_speed_i,
  output seq_state_t  state_o,
  output step_pulse_t pulse_o
);

  logic [LineW-1:0]  m3, m0, ll;
  logic [FrameW-1:0] vb, fl;

  assign m3 = double_speed_i ? MODE3_AT_DS  : MODE3_AT;
  assign m0 = double_speed_i ? MODE0_AT_DS  : MODE0_AT;
  assign ll = double_speed_i ? LINE_LEN_DS  : LINE_LEN;
  assign vb = double_speed_i ? VBLANK_AT_DS : VBLANK_AT;
  assign fl = double_speed_i ? FRAME_LEN_DS : FRAME_LEN;

  always_comb begin
    seq_state_t        ns;
    step_pulse_t       p;
    logic [FrameW-1:0] fc;
    logic [LineW-1:0]  lc;
    logic [7:0]        line_nx;
    logic              en_hb, en_vb, en_oam, en_lyc;

    ns      = state_i;
    p       = '0;
    fc      = state_i.frame_cycles + FRAME_STEP;
    lc      = state_i.line_cycles + LINE_STEP;
    line_nx = state_i.scanline + 8'd1;
    en_hb   = item_i.stat_int_enables[0];
    en_vb   = item_i.stat_int_enables[1];
    en_oam  = item_i.stat_int_enables[2];
    en_lyc  = item_i.stat_int_enables[3];

    if (item_i.mode == OP_SET_LCD) begin
      if (!item_i.lcd_on) begin
        ns.in_vblank    = 1'b1;
        ns.current_mode = MODE_VBLANK;
        ns.lcd_enabled  = 1'b0;
      end else begin
        if (!state_i.lcd_enabled) begin
          ns.in_vblank    = 1'b0;
          ns.frame_cycles = FRAME_STEP;
          ns.line_cycles  = LINE_STEP;
          ns.current_mode = MODE_OAM;
          ns.scanline     = 8'd0;
          p.window_line_clear = 1'b1;
        end
        ns.lcd_enabled = 1'b1;
      end
    end else begin
      ns.frame_cycles = fc;
      if (!state_i.lcd_enabled) begin
        // display off: only the frame counter runs
        if (fc >= fl) begin
          ns.frame_cycles = '0;
          p.frame_sync    = 1'b1;
        end
      end else begin
        ns.line_cycles = lc;
        if (fc <= vb) begin
          if (lc == m3) begin
            ns.current_mode = MODE_DRAW;
          end else if (lc == m0) begin
            ns.current_mode = MODE_HBLANK;
            p.stat_irq      = en_hb;
          end else if (lc == ll) begin
            ns.line_cycles = '0;
            ns.scanline    = line_nx;
            ns.match_flag  = (line_nx == item_i.lyc);
            if (fc != vb) begin
              ns.current_mode = MODE_OAM;
              p.stat_irq      = en_oam | (ns.match_flag & en_lyc);
            end else begin
              ns.in_vblank    = 1'b1;
              ns.current_mode = MODE_VBLANK;
              p.stat_irq      = en_vb | (ns.match_flag & en_lyc);
              p.vblank_irq    = 1'b1;
            end
          end
        end else if (fc < fl) begin
          if (lc == ll) begin
            ns.line_cycles = '0;
            ns.scanline    = line_nx;
            ns.match_flag  = (line_nx == item_i.lyc);
            p.stat_irq     = ns.match_flag & en_lyc;
          end
        end else begin
          // frame wrap
          ns.in_vblank    = 1'b0;
          ns.frame_cycles = '0;
          ns.line_cycles  = '0;
          ns.current_mode = MODE_OAM;
          ns.scanline     = 8'd0;
          ns.match_flag   = (item_i.lyc == 8'd0);
          p.frame_sync        = 1'b1;
          p.window_line_clear = 1'b1;
          p.stat_irq          = en_oam | (ns.match_flag & en_lyc);
        end
      end
    end

    state_o = ns;
    pulse_o = p;
  end

endmodule

[design/lmts_checker.sv]
`include "assert_macros.svh"

module lmts_checker
  import lmts_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic [1:0] mode_o;
  logic [7:0] line_o;
  logic       vsync_o, vbi_o, wclr_o, active_o;

  assign mode_o   = m_axis_tdata[1:0];
  assign line_o   = m_axis_tdata[9:2];
  assign vsync_o  = m_axis_tdata[11];
  assign vbi_o    = m_axis_tdata[13];
  assign wclr_o   = m_axis_tdata[14];
  assign active_o = m_axis_tdata[16];

  // stalled result beat is held
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // display off always reports vblank mode
  `ASSERT_IMPL(a_off_vblank, clk_i, rst_ni, m_axis_tvalid && !active_o,
    mode_o == MODE_VBLANK && vsync_o)

  // vblank interrupt only on entry to vblank
  `ASSERT_IMPL(a_vbi_mode, clk_i, rst_ni, m_axis_tvalid && vbi_o,
    mode_o == MODE_VBLANK && vsync_o && active_o)

  // window clear goes with a restart at line 0 in OAM mode
  `ASSERT_IMPL(a_wclr_line0, clk_i, rst_ni, m_axis_tvalid && wclr_o,
    line_o == 8'd0 && mode_o == MODE_OAM && !vsync_o)

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker u_lmts_checker (.*);

[dv/lcd_mode_timing_sequencer_core_tb.sv]
module lcd_mode_timing_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmts_pkg::*;

  localparam int unsigned LongHold = 400;
  localparam int unsigned ShownMismatches = 20;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_wdata_i   = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  // Result fields as packed on m_axis_tdata[16:0], MSB first
  typedef struct packed {
    logic       lcd_active;
    logic       frame_sync;
    logic       window_line_clear;
    logic       vblank_irq;
    logic       stat_irq;
    logic       vsync_flag;
    logic       coincidence;
    logic [7:0] line_number;
    ppu_mode_e  ppu_mode;
  } lcd_status_t;

  lcd_mode_timing_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Timing state mirrored by the predictor
  logic              fast_mode  = 1'b0;
  logic              lcd_on_q   = 1'b1;
  logic              vblank_q   = 1'b0;
  logic [FrameW-1:0] frame_cnt  = '0;
  logic [LineW-1:0]  line_cnt   = '0;
  ppu_mode_e         mode_q     = MODE_OAM;
  logic [7:0]        scanline_q = '0;
  logic              lyc_hit_q  = 1'b0;

  lcd_status_t expected_status[$];
  int unsigned mismatches    = 0;
  int unsigned beats_checked = 0;
  int unsigned hold_requests = 0;

  // Sender idle pattern
  int unsigned src_run  = 0;
  logic        src_idle = 1'b0;

  function automatic logic line_compare(input logic [7:0] lyc, input logic [3:0] en);
    lyc_hit_q = (scanline_q == lyc);
    return lyc_hit_q & en[3];
  endfunction

  function automatic lcd_status_t advance_timing(input step_in_t it);
    logic [LineW-1:0]  m3, m0, ll;
    logic [FrameW-1:0] vb, fl;
    logic              stat, vbi, wclr, fsync;
    lcd_status_t       res;
    m3 = fast_mode ? MODE3_AT_DS  : MODE3_AT;
    m0 = fast_mode ? MODE0_AT_DS  : MODE0_AT;
    ll = fast_mode ? LINE_LEN_DS  : LINE_LEN;
    vb = fast_mode ? VBLANK_AT_DS : VBLANK_AT;
    fl = fast_mode ? FRAME_LEN_DS : FRAME_LEN;
    stat  = 1'b0;
    vbi   = 1'b0;
    wclr  = 1'b0;
    fsync = 1'b0;

    if (it.mode == OP_SET_LCD) begin
      if (!it.lcd_on) begin
        vblank_q = 1'b1;
        mode_q   = MODE_VBLANK;
        lcd_on_q = 1'b0;
      end else begin
        if (!lcd_on_q) begin
          // restart from line 0; coincidence flag left as it was
          vblank_q   = 1'b0;
          frame_cnt  = FRAME_STEP;
          line_cnt   = LINE_STEP;
          mode_q     = MODE_OAM;
          scanline_q = '0;
          wclr       = 1'b1;
        end
        lcd_on_q = 1'b1;
      end
    end else begin
      frame_cnt = frame_cnt + FRAME_STEP;
      if (!lcd_on_q) begin
        if (frame_cnt >= fl) begin
          frame_cnt = '0;
          fsync     = 1'b1;
        end
      end else begin
        line_cnt = line_cnt + LINE_STEP;
        if (frame_cnt <= vb) begin
          if (line_cnt == m3) begin
            mode_q = MODE_DRAW;
          end else if (line_cnt == m0) begin
            mode_q = MODE_HBLANK;
            if (it.stat_int_enables[0]) stat = 1'b1;
          end else if (line_cnt == ll) begin
            line_cnt   = '0;
            scanline_q = scanline_q + 8'd1;
            stat       = stat | line_compare(it.lyc, it.stat_int_enables);
            if (frame_cnt != vb) begin
              mode_q = MODE_OAM;
              if (it.stat_int_enables[2]) stat = 1'b1;
            end else begin
              vblank_q = 1'b1;
              mode_q   = MODE_VBLANK;
              if (it.stat_int_enables[1]) stat = 1'b1;
              vbi = 1'b1;
            end
          end
        end else if (frame_cnt < fl) begin
          if (line_cnt == ll) begin
            line_cnt   = '0;
            scanline_q = scanline_q + 8'd1;
            stat       = stat | line_compare(it.lyc, it.stat_int_enables);
          end
        end else begin
          fsync      = 1'b1;
          vblank_q   = 1'b0;
          frame_cnt  = '0;
          line_cnt   = '0;
          mode_q     = MODE_OAM;
          if (it.stat_int_enables[2]) stat = 1'b1;
          scanline_q = '0;
          wclr       = 1'b1;
          stat       = stat | line_compare(it.lyc, it.stat_int_enables);
        end
      end
    end

    res.ppu_mode          = mode_q;
    res.line_number       = scanline_q;
    res.coincidence       = lyc_hit_q;
    res.vsync_flag        = vblank_q;
    res.stat_irq          = stat;
    res.vblank_irq        = vbi;
    res.window_line_clear = wclr;
    res.frame_sync        = fsync;
    res.lcd_active        = lcd_on_q;
    return res;
  endfunction

  function automatic step_in_t make_step(input logic op, input logic on,
                                         input logic [7:0] lyc, input logic [3:0] en);
    step_in_t it;
    it.mode             = op;
    it.lcd_on           = on;
    it.lyc              = lyc;
    it.stat_int_enables = en;
    return it;
  endfunction

  // Half the time aim LYC at the next line so coincidence actually fires
  function automatic logic [7:0] pick_lyc();
    return $urandom_range(0, 1) ? scanline_q + 8'd1 : 8'($urandom_range(0, 255));
  endfunction

  function automatic step_in_t random_step();
    logic op;
    op = ($urandom_range(0, 99) < 6) ? OP_SET_LCD : OP_TICK;
    return make_step(op, $urandom_range(0, 9) < 7, pick_lyc(), 4'($urandom_range(0, 15)));
  endfunction

  function automatic int unsigned pick_gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= ShownMismatches)
      $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, field, got,
               want);
  endtask

  task automatic send_step(input step_in_t it);
    int unsigned gap;
    if (src_run == 0) begin
      src_run  = $urandom_range(20, 400);
      src_idle = ($urandom_range(0, 2) != 0);
    end
    src_run--;
    gap = (src_idle && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.stat_int_enables, it.lyc, it.lcd_on};
    s_axis_tuser  <= it.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_status.push_back(advance_timing(it));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
  endtask

  // Speed write also clears both cycle counters
  task automatic set_speed(input logic fast);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fast;
    fast_mode = fast;
    frame_cnt = '0;
    line_cnt  = '0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_step(make_step(OP_TICK, 1'b0, 8'd0, 4'h0));
    send_step(make_step(OP_TICK, 1'b1, 8'd255, 4'hF));
    send_step(make_step(OP_SET_LCD, 1'b1, 8'd255, 4'hF));  // on while on
    send_step(make_step(OP_SET_LCD, 1'b0, 8'd0, 4'h0));
    send_step(make_step(OP_SET_LCD, 1'b0, 8'd255, 4'hF));  // off while off
    send_step(make_step(OP_TICK, 1'b1, 8'd0, 4'hF));       // only frame counter moves
    send_step(make_step(OP_SET_LCD, 1'b1, 8'd0, 4'hF));    // restart at line 0
    send_step(make_step(OP_SET_LCD, 1'b1, 8'd1, 4'h0));
    repeat (19) send_step(make_step(OP_TICK, 1'b0, 8'd1, 4'hF));  // up to drawing
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      set_speed(phase == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
      // long sink stall while beats keep coming, fills the pipe
      if (phase == 1) hold_requests++;
      repeat (250) send_step(random_step());
    end
  endtask

  always @(posedge clk_i) begin : ready_gen
    int unsigned stall_left;
    int unsigned run_left;
    int unsigned holds_done;
    logic        idling;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = LongHold;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(20, 400);
        idling   = ($urandom_range(0, 2) != 0);
      end
      run_left--;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    lcd_status_t got;
    lcd_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lcd_status_t'(m_axis_tdata[16:0]);
      if (expected_status.size() == 0) begin
        report_mismatch("beat with nothing expected", m_axis_tdata, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.ppu_mode !== want.ppu_mode)
          report_mismatch("ppu_mode", got.ppu_mode, want.ppu_mode);
        if (got.line_number !== want.line_number)
          report_mismatch("line_number", got.line_number, want.line_number);
        if (got.coincidence !== want.coincidence)
          report_mismatch("coincidence", got.coincidence, want.coincidence);
        if (got.vsync_flag !== want.vsync_flag)
          report_mismatch("vsync_flag", got.vsync_flag, want.vsync_flag);
        if (got.stat_irq !== want.stat_irq)
          report_mismatch("stat_irq", got.stat_irq, want.stat_irq);
        if (got.vblank_irq !== want.vblank_irq)
          report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
        if (got.window_line_clear !== want.window_line_clear)
          report_mismatch("window_line_clear", got.window_line_clear,
                          want.window_line_clear);
        if (got.frame_sync !== want.frame_sync)
          report_mismatch("frame_sync", got.frame_sync, want.frame_sync);
        if (got.lcd_active !== want.lcd_active)
          report_mismatch("lcd_active", got.lcd_active, want.lcd_active);
      end
      beats_checked++;
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/lmts_pkg.sv
design/lmts_step.sv
design/lcd_mode_timing_sequencer_core.sv
design/lmts_checker.sv
dv/lcd_mode_timing_sequencer_core_tb.sv
